// ===== hdl/max_duplicate_count_defines.svh =====
// Assertion macros of the mode frequency counter RTL.
`ifndef MAX_DUPLICATE_COUNT_DEFINES_SVH
`define MAX_DUPLICATE_COUNT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and silenced during reset.
`define MDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mdc assertion failed");

// Next-cycle implication, sampled on clk_i and silenced during reset.
`define MDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mdc assertion failed");

`endif

// ===== hdl/mdc_pkg.sv =====
// Types, sizes and helpers of the mode frequency counter.
`default_nettype none
package mdc_pkg;

  localparam int MaxItems      = 256;
  localparam int CntW          = $clog2(MaxItems + 1);
  localparam int ElemW         = $clog2(MaxItems + 2);
  localparam int CountFieldMax = 511;
  localparam int WideW         = CntW + 9;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [8:0] max_count;
    logic       overflow;
  } out_item_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic               en;
    logic               clear;
    logic signed [31:0] value;
  } cell_ctl_t;

  // Summary that the chain returns for the item being counted.
  typedef struct packed {
    logic            hit_any;
    logic [CntW-1:0] new_count;
  } chain_stat_t;

  // Clamps an occurrence count to the width of the result field.
  function automatic logic [8:0] sat_count(input logic [CntW-1:0] c);
    logic [WideW-1:0] wide;
    wide = {{9{1'b0}}, c};
    if (wide > WideW'(CountFieldMax)) begin
      return 9'(CountFieldMax);
    end
    return wide[8:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/max_duplicate_count.sv =====
// Top level of the mode frequency counter: handshakes, set bookkeeping, result.
//
//   channel   direction  payload              transfer when
//   in        input      value, last_item     in_valid_i && in_ready_o
//   out       output     max_count, overflow  out_valid_o && out_ready_i
//
// One item is taken per cycle. An item is matched against the whole cell row
// in the cycle it is accepted; in the next cycle its new count meets the running
// maximum, and a last item's result lands in the output register after that.
// Reset clears the occupied bits of all cells at once, so there is no clearing
// pass. Input stalls only while a finished result waits and a later set's last
// item is queued behind it.
`default_nettype none
`include "max_duplicate_count_defines.svh"
module max_duplicate_count (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mdc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mdc_pkg::out_item_t out_data_o
);
  import mdc_pkg::*;

  logic              in_fire;
  logic              counted;
  logic              advance;
  logic              out_free;
  cell_ctl_t         ctl;
  chain_stat_t       stat;
  logic [ElemW-1:0]  elem_q, elem_d;
  logic              ovf_q, ovf_d;
  logic              s1_valid_q;
  logic              s1_last_q;
  logic              s1_ovf_q;
  logic [CntW-1:0]   s1_cnt_q;
  logic [CntW-1:0]   rm_q, rm_d;
  logic [CntW-1:0]   max_now;
  logic              out_valid_q;
  out_item_t         out_q;

  assign in_fire = in_valid_i && in_ready_o;
  // Elements past the first MaxItems of a set only raise the overflow flag.
  assign counted = elem_q < ElemW'(MaxItems);

  assign ctl.en    = in_fire && counted;
  assign ctl.clear = in_fire && in_data_i.last_item;
  assign ctl.value = in_data_i.value;

  mdc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat)
  );

  // The second stage moves unless it holds a last item whose result cannot
  // yet enter the output register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = !s1_valid_q || !s1_last_q || out_free;
  assign in_ready_o = advance;

  always_comb begin
    elem_d = elem_q;
    ovf_d  = ovf_q;
    if (in_fire) begin
      if (elem_q < ElemW'(MaxItems + 1)) begin
        elem_d = elem_q + ElemW'(1);
      end
      if (!counted) begin
        ovf_d = 1'b1;
      end
      if (in_data_i.last_item) begin
        elem_d = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  assign max_now = (s1_cnt_q > rm_q) ? s1_cnt_q : rm_q;

  always_comb begin
    rm_d = rm_q;
    if (advance && s1_valid_q) begin
      rm_d = s1_last_q ? '0 : max_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q      <= '0;
      ovf_q       <= 1'b0;
      rm_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      elem_q <= elem_d;
      ovf_q  <= ovf_d;
      rm_q   <= rm_d;
      if (advance) begin
        s1_valid_q <= in_fire;
      end
      if (advance && s1_valid_q && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_last_q <= in_data_i.last_item;
      s1_ovf_q  <= ovf_q || !counted;
      s1_cnt_q  <= stat.new_count;
    end
    if (advance && s1_valid_q && s1_last_q) begin
      out_q.max_count <= sat_count(max_now);
      out_q.overflow  <= s1_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MDC_ASSERT_NEXT(a_last_restarts_set, in_fire && in_data_i.last_item, elem_q == '0 && !ovf_q)
  `MDC_ASSERT_NEXT(a_stalled_last_held, s1_valid_q && s1_last_q && !advance,
                   s1_valid_q && s1_last_q)
  `MDC_ASSERT_NOW(a_result_nonzero, out_valid_o, out_data_o.max_count != 9'd0)
  `MDC_ASSERT_NOW(a_counted_has_count, ctl.en, stat.new_count != '0)
  `MDC_ASSERT_NOW(a_hit_repeats_value, stat.hit_any, stat.new_count > CntW'(1))

endmodule
`default_nettype wire

// ===== hdl/mdc_cell.sv =====
// One table cell: a stored value, its occurrence count and an occupied bit.
`default_nettype none
module mdc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mdc_pkg::cell_ctl_t       ctl_i,
  input  logic                     hit_any_i,
  input  logic                     prev_occ_i,
  output logic                     occ_o,
  output logic                     hit_o,
  output logic [mdc_pkg::CntW-1:0] new_count_o
);
  import mdc_pkg::*;

  logic                     occ_q, occ_d;
  logic signed [31:0]       val_q, val_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     alloc;

  assign hit_o = ctl_i.en && occ_q && (val_q == ctl_i.value);
  // The free cell right after the last occupied one takes a new value.
  assign alloc = ctl_i.en && !occ_q && prev_occ_i && !hit_any_i;
  assign occ_o = occ_q;

  always_comb begin
    occ_d       = occ_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    new_count_o = '0;
    if (hit_o) begin
      cnt_d       = cnt_q + CntW'(1);
      new_count_o = cnt_q + CntW'(1);
    end else if (alloc) begin
      occ_d       = 1'b1;
      val_d       = ctl_i.value;
      cnt_d       = CntW'(1);
      new_count_o = CntW'(1);
    end
    if (ctl_i.clear) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
  end

endmodule
`default_nettype wire

// ===== hdl/mdc_chain.sv =====
// Row of table cells with the hit and count reductions across it.
`default_nettype none
module mdc_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mdc_pkg::cell_ctl_t   ctl_i,
  output mdc_pkg::chain_stat_t stat_o
);
  import mdc_pkg::*;

  logic [MaxItems-1:0]           occ;
  logic [MaxItems-1:0]           hit;
  logic [MaxItems-1:0][CntW-1:0] cnt;
  logic [MaxItems:0]             prev_occ;
  logic                          hit_any;

  assign prev_occ[0] = 1'b1;
  assign hit_any     = |hit;

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    assign prev_occ[i+1] = occ[i];
    mdc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .hit_any_i   (hit_any),
      .prev_occ_i  (prev_occ[i]),
      .occ_o       (occ[i]),
      .hit_o       (hit[i]),
      .new_count_o (cnt[i])
    );
  end

  // Values in the table are distinct, so at most one cell reports a count.
  always_comb begin
    stat_o.hit_any   = hit_any;
    stat_o.new_count = '0;
    for (int i = 0; i < MaxItems; i++) begin
      stat_o.new_count = stat_o.new_count | cnt[i];
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_max_duplicate_count.sv =====
// Self-checking testbench of the mode frequency counter, with random idling on both channels.
`timescale 1ns / 1ps
`default_nettype none
module tb_max_duplicate_count;
  import mdc_pkg::*;

  // A run is stopped when no transfer on either channel happens for this many cycles.
  localparam int unsigned QuietLimit = 1000;
  // Cycles to wait after the last expected result before the final verdict.
  localparam int unsigned DrainCycles = 20;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  max_duplicate_count i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Predicted state of the current set: the distinct values seen so far with their
  // occurrence counts, the highest count, the element count (saturating one past the
  // table size) and whether the set has grown too long.
  logic [31:0] tbl_value [MaxItems];
  int unsigned tbl_count [MaxItems];
  int unsigned distinct_used;
  int unsigned peak_count;
  int unsigned set_length;
  logic        set_overflow;

  // Mode frequencies predicted for sets whose last element has been transferred.
  out_item_t expected_modes[$];

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned ready_hold;
  bit          idle_bursts_on;
  bit          stall_bursts_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void clear_set_state();
    foreach (tbl_count[i]) tbl_count[i] = 0;
    distinct_used = 0;
    peak_count    = 0;
    set_length    = 0;
    set_overflow  = 1'b0;
  endfunction

  // Folds one transferred element into the predicted set state. A last element closes
  // the set and queues the expected result.
  function automatic void count_into_set(input in_item_t item);
    int        hit;
    out_item_t res;
    if (set_length < MaxItems + 1) set_length++;
    if (set_length > MaxItems) begin
      // Elements past the table size only raise the flag; they are not counted.
      set_overflow = 1'b1;
    end else begin
      hit = -1;
      for (int i = 0; i < distinct_used; i++) begin
        // The comparison is on the raw 32-bit pattern.
        if (tbl_value[i] == 32'(item.value)) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        hit = distinct_used;
        tbl_value[hit] = item.value;
        tbl_count[hit] = 0;
        distinct_used++;
      end
      tbl_count[hit]++;
      if (tbl_count[hit] > peak_count) peak_count = tbl_count[hit];
    end
    if (item.last_item) begin
      res.max_count = (peak_count > CountFieldMax) ? 9'(CountFieldMax) : 9'(peak_count);
      res.overflow  = set_overflow;
      expected_modes.push_back(res);
      clear_set_state();
    end
  endfunction

  // Both channels are observed here with the values they held just before the edge.
  // The output side is handled first so that a result is always matched against the
  // expectations queued at earlier edges.
  always @(posedge clk_i) begin : channel_monitor
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_modes.size() == 0) begin
          report_mismatch($sformatf("result max_count=%0d overflow=%0b with none expected",
                                    out_data_o.max_count, out_data_o.overflow));
        end else begin
          want = expected_modes.pop_front();
          if (out_data_o.max_count !== want.max_count) begin
            report_mismatch($sformatf("max_count %0d, expected %0d",
                                      out_data_o.max_count, want.max_count));
          end
          if (out_data_o.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      out_data_o.overflow, want.overflow));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        count_into_set(in_data_i);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // The receiver stalls in random bursts while stall bursts are on.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (stall_bursts_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold = $urandom_range(0, 14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // Sends one element and returns at the edge of its transfer. Valid is left high so
  // that the next element can follow without a gap; an idle burst lowers it first.
  task automatic send_item(input logic [31:0] value, input logic last);
    in_item_t item;
    item.value     = value;
    item.last_item = last;
    if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_set(input logic [31:0] vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // A set of one element reports a count of one, for the extreme patterns.
  task automatic test_single_element_sets();
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7fff_ffff, 1'b1);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hffff_ffff, 1'b1);
  endtask

  // Values that differ only in the sign bit or sit at the range ends must not match.
  task automatic test_bit_pattern_compare();
    send_set('{32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    send_set('{32'h0000_0001, 32'h8000_0001, 32'h0000_0001});
  endtask

  task automatic test_repeated_values();
    send_set('{32'd5, 32'd5, 32'd7, 32'd5});
    send_set('{32'd1, 32'd2, 32'd3, 32'd4});
  endtask

  // Exactly as many distinct values as the table holds: every cell gets used.
  task automatic test_full_table();
    logic [31:0] vals[$];
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < MaxItems; i++) vals.push_back(base ^ 32'(i));
    send_set(vals);
  endtask

  // Sets one and two elements longer than the table. The count of one repeated value
  // reaches the table size, which sets the top bit of the count field. Elements past
  // the limit match a stored value but must not be counted.
  task automatic test_too_many_elements();
    logic [31:0] vals[$];
    logic [31:0] val_a;
    logic [31:0] val_b;
    val_a = $urandom;
    val_b = ~val_a;
    repeat (MaxItems + 1) vals.push_back(val_a);
    send_set(vals);
    vals.delete();
    repeat (MaxItems / 2) vals.push_back(val_a);
    repeat (MaxItems / 2) vals.push_back(val_b);
    vals.push_back(val_a);
    vals.push_back(val_a);
    send_set(vals);
  endtask

  // Random sets, mostly short. Elements are drawn from a small pool of values so that
  // duplicates are common; some pool members differ from another in one bit only, and
  // some elements are fresh random patterns.
  task automatic test_random_sets(input int unsigned item_goal, input bit with_bursts);
    int unsigned sent;
    int unsigned len;
    logic [31:0] pool[4];
    logic [31:0] vals[$];
    idle_bursts_on  = with_bursts;
    stall_bursts_on = with_bursts;
    sent = 0;
    while (sent < item_goal) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      foreach (pool[k]) pool[k] = $urandom;
      if ($urandom_range(0, 2) == 0) pool[1] = pool[0] ^ (32'h1 << $urandom_range(0, 31));
      vals.delete();
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) vals.push_back($urandom);
        else vals.push_back(pool[$urandom_range(0, 3)]);
      end
      send_set(vals);
      sent += len;
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_data_i       <= '0;
    out_ready_i     <= 1'b0;
    ready_hold      = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    idle_bursts_on  = 1'b0;
    stall_bursts_on = 1'b0;
    clear_set_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_bursts_on  = 1'b1;
    stall_bursts_on = 1'b1;
    test_single_element_sets();
    test_bit_pattern_compare();
    test_repeated_values();
    test_full_table();
    test_too_many_elements();
    test_random_sets(450, 1'b1);
    // The closing stretch runs at full rate on both channels.
    test_random_sets(150, 1'b0);
    in_valid_i <= 1'b0;

    while (expected_modes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/mdc_pkg.sv
hdl/mdc_cell.sv
hdl/mdc_chain.sv
hdl/max_duplicate_count.sv
tb/tb_max_duplicate_count.sv
